// ===== sv/pti_pkg.sv =====
// Package for the polynomial trapezoid integrator: widths, constants, arithmetic helpers.
package pti_pkg;

    localparam int MAX_TERMS_DEF = 5;
    localparam int MAX_STEPS_DEF = 1048576;
    localparam int COEF_SLOTS    = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEPS_W    = 21;
    localparam int TC_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;

    localparam logic OP_TRAP  = 1'b0;
    localparam logic OP_EXACT = 1'b1;

    // datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;
    localparam logic [3:0] CMD_DIV_START = 4'd2;
    localparam logic [3:0] CMD_DIV_STEP  = 4'd3;
    localparam logic [3:0] CMD_DIV_DONE  = 4'd4;
    localparam logic [3:0] CMD_HORNER    = 4'd5;
    localparam logic [3:0] CMD_SAMPLE    = 4'd6;
    localparam logic [3:0] CMD_ACCUM     = 4'd7;
    localparam logic [3:0] CMD_ENDS      = 4'd8;
    localparam logic [3:0] CMD_FINAL     = 4'd9;
    localparam logic [3:0] CMD_EXACT     = 4'd10;
    localparam logic [3:0] CMD_POLY_INIT = 4'd11;

    typedef struct packed {
        logic [3:0] cmd;
        logic [3:0] sel;      // poly target / term index
    } pti_cmd_t;

    typedef struct packed {
        logic div_busy;
    } pti_stat_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        mag64 = a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg,
                                                    output logic f);
        f = 1'b0;
        if (neg)
        begin
            if (m > 64'h8000_0000_0000_0000)
            begin
                f = 1'b1;
                from_mag = 64'sh8000_0000_0000_0000;
            end
            else
            begin
                from_mag = 64'd0 - m;
            end
        end
        else if (m[63])
        begin
            f = 1'b1;
            from_mag = 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            from_mag = m;
        end
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   output logic f);
        logic signed [63:0] s;
        s = a + b;
        f = 1'b0;
        sat_add = s;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            f = 1'b1;
            sat_add = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   output logic f);
        logic signed [63:0] s;
        s = a - b;
        f = 1'b0;
        sat_sub = s;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            f = 1'b1;
            sat_sub = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
    endfunction

endpackage

// ===== sv/pti_mul.sv =====
// Multi-cycle rounding saturating multiplier: 64-bit by 33-bit magnitude, shift 24 or 25.
module pti_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic               shift25,
    output logic               done,
    output logic signed [63:0] prod,
    output logic               ovf
);
    // phase 0 idle and operand capture, phase 1 low half product, phase 2 high half product, phase 3 combine
    logic [1:0]  ph_reg, ph_next;
    logic [31:0] lo_reg, hi_reg;
    logic [32:0] mb_reg;
    logic        neg_reg, s25_reg;
    logic [64:0] plo_reg, phi_reg;
    logic [63:0] ma, mb_full;
    logic [32:0] mb_c;
    logic [64:0] pm;
    logic [63:0] res;
    logic        f0;
    logic signed [63:0] fm;

    assign ma      = pti_pkg::mag64(a);
    assign mb_full = pti_pkg::mag64(b);
    assign mb_c    = (mb_full > 64'h1_0000_0000) ? 33'h1_0000_0000 : mb_full[32:0];
    assign pm      = (ph_reg == 2'd1) ? {33'd0, lo_reg} * {32'd0, mb_reg}
                                      : {33'd0, hi_reg} * {32'd0, mb_reg};

    always_comb
    begin
        logic [64:0] rnd;
        logic        big;
        rnd = s25_reg ? ((plo_reg + 65'h100_0000) >> 25) : ((plo_reg + 65'h80_0000) >> 24);
        big = s25_reg ? (phi_reg[64:56] != 9'd0) : (phi_reg[64:55] != 10'd0);
        res = (s25_reg ? {phi_reg[56:0], 7'd0} : {phi_reg[55:0], 8'd0}) + rnd[63:0];
        fm  = pti_pkg::from_mag(res, neg_reg, f0);
        if (big)
        begin
            fm = neg_reg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            f0 = 1'b1;
        end
    end

    always_comb
    begin
        ph_next = ph_reg;
        unique case (ph_reg)
            2'd0: if (start) ph_next = 2'd1;
            2'd1: ph_next = 2'd2;
            2'd2: ph_next = 2'd3;
            default: ph_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= 2'd0;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == 2'd0 && start)
        begin
            lo_reg  <= ma[31:0];
            hi_reg  <= ma[63:32];
            mb_reg  <= mb_c;
            neg_reg <= a[63] ^ b[63];
            s25_reg <= shift25;
        end
        if (ph_reg == 2'd1) plo_reg <= pm;
        if (ph_reg == 2'd2) phi_reg <= pm;
        if (ph_reg == 2'd3)
        begin
            prod <= fm;
            ovf  <= f0;
        end
    end

    assign done = 1'b0 | (ph_reg == 2'd0 && !start);
endmodule

// ===== sv/pti_div.sv =====
// Restoring divider, one quotient bit per cycle, with half-away-from-zero rounding.
module pti_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic [23:0]        den,
    output logic               busy,
    output logic signed [63:0] quo,
    output logic               ovf
);
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [24:0] r_reg;
    logic [23:0] d_reg;
    logic        neg_reg;
    logic        run_reg;
    logic [24:0] rs;
    logic [63:0] qr;
    logic        fo;
    logic signed [63:0] qs;

    assign rs = {r_reg[23:0], q_reg[63]};
    assign qr = q_reg + {63'd0, ({1'b0, r_reg[23:0]} >= ({1'b0, d_reg} - {2'b0, d_reg[23:1]}))};
    assign busy = run_reg;

    always_comb
    begin
        qs = pti_pkg::from_mag(qr, neg_reg, fo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 7'd0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'd64) run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= pti_pkg::mag64(num);
            r_reg   <= 25'd0;
            d_reg   <= den;
            neg_reg <= num[63];
        end
        else if (run_reg && cnt_reg < 7'd64)
        begin
            if (rs >= {1'b0, d_reg})
            begin
                r_reg <= rs - {1'b0, d_reg};
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= rs;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
        else if (run_reg)
        begin
            quo <= qs;
            ovf <= fo;
        end
    end
endmodule

// ===== sv/pti_datapath.sv =====
// Datapath: registers, Horner evaluation, accumulation, exact-mode terms.
module pti_datapath
#(
    parameter int MAX_TERMS = pti_pkg::MAX_TERMS_DEF,
    parameter int MAX_STEPS = pti_pkg::MAX_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [31:0]   lower_bound,
    input  logic signed [31:0]   upper_bound,
    input  logic [20:0]          steps,
    input  pti_pkg::pti_cmd_t    cmd,
    output logic [3:0]           nterms,
    output logic [24:0]          nsteps,
    output logic                 mul_done,
    output logic                 div_busy,
    output logic signed [63:0]   integral,
    output logic                 overflow
);
    logic [2:0]          tc_reg;
    logic signed [31:0]  coef_reg [pti_pkg::COEF_SLOTS];
    logic signed [63:0]  lo_reg, hi_reg, h_reg, x_reg, acc_reg, sum_reg;
    logic signed [63:0]  pt_reg, pa_reg, pb_reg, res_reg, t_reg;
    logic                f_reg;
    logic [24:0]         n_reg;
    logic signed [63:0]  ma, mb, mp;
    logic                ms25, mstart, mov;
    logic signed [63:0]  dnum, dq;
    logic [23:0]         dden;
    logic                dstart, dov;
    logic [3:0]          nt;

    always_comb
    begin
        nt = {1'b0, tc_reg};
        if (nt == 4'd0) nt = 4'd1;
        if (nt > 4'(MAX_TERMS)) nt = 4'(MAX_TERMS);
        if (nt > 4'(pti_pkg::COEF_SLOTS)) nt = 4'(pti_pkg::COEF_SLOTS);
    end
    assign nterms = nt;
    assign nsteps = n_reg;

    function automatic logic signed [63:0] cf(input logic [3:0] i,
                                              input logic signed [31:0] c [pti_pkg::COEF_SLOTS]);
        cf = 64'sd0;
        for (int j = 0; j < pti_pkg::COEF_SLOTS; j++)
            if (i == 4'(j)) cf = 64'(c[j]);
    endfunction

    // multiplier and divider operand select
    always_comb
    begin
        ma = acc_reg; mb = x_reg; ms25 = 1'b0; mstart = 1'b0;
        dnum = 64'sd0; dden = 24'd1; dstart = 1'b0;
        unique case (cmd.cmd)
            pti_pkg::CMD_HORNER: mstart = 1'b1;
            pti_pkg::CMD_FINAL:
            begin
                mstart = 1'b1;
                ms25 = cmd.sel[0];
                ma = cmd.sel[0] ? t_reg : sum_reg;
                mb = h_reg;
            end
            pti_pkg::CMD_EXACT:
            begin
                mstart = 1'b1;
                unique case (cmd.sel[1:0])
                    2'd0: begin ma = t_reg; mb = cf(cmd.sel[3:2] == 2'd0 ? x_reg[3:0] : 4'd0, coef_reg); end
                    2'd1: begin ma = pa_reg; mb = lo_reg; end
                    2'd2: begin ma = pb_reg; mb = hi_reg; end
                    default: begin ma = t_reg; mb = x_reg; end
                endcase
            end
            pti_pkg::CMD_DIV_START:
            begin
                dstart = 1'b1;
                dnum = cmd.sel[0] ? t_reg : (hi_reg - lo_reg);
                dden = cmd.sel[0] ? {20'd0, x_reg[3:0] + 4'd1} : n_reg[23:0];
            end
            default: ;
        endcase
    end

    pti_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .shift25(ms25),
                   .done(mul_done), .prod(mp), .ovf(mov));
    pti_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
                   .busy(div_busy), .quo(dq), .ovf(dov));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= 3'd5;
            for (int j = 0; j < pti_pkg::COEF_SLOTS; j++) coef_reg[j] <= 32'sd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pti_pkg::REG_TERM_COUNT) tc_reg <= cfg_data[2:0];
            else
                for (int j = 0; j < pti_pkg::COEF_SLOTS; j++)
                    if (cfg_index == 3'(j + 1) && j < MAX_TERMS) coef_reg[j] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        logic fa;
        logic signed [63:0] s, xs;
        fa = 1'b0;
        unique case (cmd.cmd)
            pti_pkg::CMD_LOAD:
            begin
                lo_reg  <= 64'(lower_bound);
                hi_reg  <= 64'(upper_bound);
                f_reg   <= 1'b0;
                sum_reg <= 64'sd0;
                res_reg <= 64'sd0;
                pa_reg  <= 64'(lower_bound);
                pb_reg  <= 64'(upper_bound);
                pt_reg  <= 64'(lower_bound);
                x_reg   <= 64'sd0;
                if (steps == 21'd0) n_reg <= 25'd1;
                else if (25'(steps) > 25'(MAX_STEPS)) n_reg <= 25'(MAX_STEPS);
                else n_reg <= 25'(steps);
            end
            pti_pkg::CMD_DIV_DONE:
            begin
                if (cmd.sel[0])
                begin
                    s = pti_pkg::sat_add(res_reg, dq, fa);
                    res_reg <= s;
                end
                else
                begin
                    h_reg <= dq;
                end
                f_reg <= f_reg | dov | fa;
            end
            pti_pkg::CMD_POLY_INIT:
            begin
                // sel 0 sample point, 1 lower, 2 upper
                unique case (cmd.sel[1:0])
                    2'd1: xs = lo_reg;
                    2'd2: xs = hi_reg;
                    default:
                    begin
                        // pt_reg walks lower + k*h one step per sample
                        xs = pt_reg;
                        if (xs > 64'sd2147483647) begin xs = 64'sd2147483647; fa = 1'b1; end
                        else if (xs < -64'sd2147483648) begin xs = -64'sd2147483648; fa = 1'b1; end
                    end
                endcase
                x_reg   <= xs;
                acc_reg <= cf(nt - 4'd1, coef_reg);
                f_reg   <= f_reg | fa;
            end
            pti_pkg::CMD_HORNER: ;
            pti_pkg::CMD_SAMPLE:
            begin
                // mul result ready: add coefficient sel
                s = pti_pkg::sat_add(mp, cf(cmd.sel, coef_reg), fa);
                acc_reg <= s;
                f_reg <= f_reg | mov | fa;
            end
            pti_pkg::CMD_ACCUM:
            begin
                unique case (cmd.sel[1:0])
                    2'd0:
                    begin
                        s = pti_pkg::sat_add(sum_reg, acc_reg, fa);
                        sum_reg <= s;
                        pt_reg <= pt_reg + h_reg;
                    end
                    2'd1: t_reg <= acc_reg;
                    default:
                    begin
                        s = pti_pkg::sat_add(t_reg, acc_reg, fa);
                        t_reg <= s;
                    end
                endcase
                f_reg <= f_reg | fa;
            end
            pti_pkg::CMD_ENDS:
            begin
                // sel 0: latch product as sum*h; 1: subtract ends*h/2
                if (cmd.sel[0])
                begin
                    s = pti_pkg::sat_sub(res_reg, mp, fa);
                    res_reg <= s;
                end
                else res_reg <= mp;
                f_reg <= f_reg | mov | fa;
            end
            pti_pkg::CMD_EXACT: ;
            pti_pkg::CMD_DIV_START: ;
            pti_pkg::CMD_FINAL: ;
            pti_pkg::CMD_DIV_STEP:
            begin
                // exact-mode steps: sel 0 d = pb - pa, else product capture to sel[1:0] target; x_reg counts the term
                unique case (cmd.sel[1:0])
                    2'd0:
                    begin
                        s = pti_pkg::sat_sub(pb_reg, pa_reg, fa);
                        t_reg <= s;
                    end
                    2'd1: begin pa_reg <= mp; x_reg <= x_reg + 64'sd1; end
                    2'd2: pb_reg <= mp;
                    default: t_reg <= mp;
                endcase
                f_reg <= f_reg | fa | ((cmd.sel[1:0] != 2'd0) ? mov : 1'b0);
            end
            default: ;
        endcase
    end

    assign integral = res_reg;
    assign overflow = f_reg;
endmodule

// ===== sv/pti_ctrl.sv =====
// Controller state machine sequencing the datapath for one beat at a time.
module pti_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               op,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         nterms,
    input  logic [24:0]        nsteps,
    input  logic               mul_done,
    input  logic               div_busy,
    output pti_pkg::pti_cmd_t  cmd
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_LOAD = 5'd1,  S_HDIV = 5'd2,  S_HWAIT = 5'd3,
                           S_PINIT = 5'd4, S_HMUL = 5'd5,  S_HWT = 5'd6,   S_HADD = 5'd7,
                           S_PDONE = 5'd8, S_FMUL = 5'd9,  S_FWT = 5'd10,  S_FCAP = 5'd11,
                           S_OUT = 5'd12,  S_ED = 5'd13,   S_EM = 5'd14,   S_EMW = 5'd15,
                           S_EMC = 5'd16,  S_EDV = 5'd17,  S_EDW = 5'd18,  S_EPW = 5'd19,
                           S_EPC = 5'd20,  S_DIVW = 5'd21, S_EPB = 5'd22;

    logic [4:0]  st_reg, st_next;
    logic [3:0]  i_reg, i_next;        // Horner index or term index
    logic [1:0]  tgt_reg, tgt_next;    // 0 sample, 1 lower, 2 upper
    logic        fin_reg, fin_next;
    logic [24:0] k_reg, k_next;
    logic        op_reg, op_next;

    assign in_stall  = (st_reg != S_IDLE);
    assign out_valid = (st_reg == S_OUT);

    always_comb
    begin
        st_next = st_reg; i_next = i_reg; tgt_next = tgt_reg; fin_next = fin_reg;
        k_next = k_reg; op_next = op_reg;
        cmd = '{cmd: pti_pkg::CMD_NONE, sel: 4'd0};
        unique case (st_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.cmd = pti_pkg::CMD_LOAD;
                    op_next = op;
                    st_next = S_LOAD;
                end
            S_LOAD:
                if (op_reg == pti_pkg::OP_EXACT)
                begin
                    i_next = 4'd0;
                    st_next = S_ED;
                end
                else
                begin
                    cmd.cmd = pti_pkg::CMD_DIV_START;
                    st_next = S_HWAIT;
                end
            S_HWAIT:
                if (!div_busy)
                begin
                    cmd.cmd = pti_pkg::CMD_DIV_DONE;
                    k_next = 25'd0; tgt_next = 2'd0;
                    st_next = S_PINIT;
                end
            S_PINIT:
            begin
                cmd = '{cmd: pti_pkg::CMD_POLY_INIT, sel: {2'd0, tgt_reg}};
                i_next = nterms - 4'd1;
                st_next = S_HMUL;
            end
            S_HMUL:
                if (i_reg == 4'd0) st_next = S_PDONE;
                else
                begin
                    cmd.cmd = pti_pkg::CMD_HORNER;
                    st_next = S_HWT;
                end
            S_HWT:
                if (mul_done) st_next = S_HADD;
            S_HADD:
            begin
                cmd = '{cmd: pti_pkg::CMD_SAMPLE, sel: i_reg - 4'd1};
                i_next = i_reg - 4'd1;
                st_next = S_HMUL;
            end
            S_PDONE:
            begin
                cmd = '{cmd: pti_pkg::CMD_ACCUM, sel: {2'd0, tgt_reg}};
                if (tgt_reg == 2'd0)
                begin
                    k_next = k_reg + 25'd1;
                    if (k_reg == nsteps) tgt_next = 2'd1;
                    st_next = S_PINIT;
                end
                else if (tgt_reg == 2'd1)
                begin
                    tgt_next = 2'd2;
                    st_next = S_PINIT;
                end
                else
                begin
                    fin_next = 1'b0;
                    st_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                cmd = '{cmd: pti_pkg::CMD_FINAL, sel: {3'd0, fin_reg}};
                st_next = S_FWT;
            end
            S_FWT:
                if (mul_done) st_next = S_FCAP;
            S_FCAP:
            begin
                cmd = '{cmd: pti_pkg::CMD_ENDS, sel: {3'd0, fin_reg}};
                if (fin_reg) st_next = S_OUT;
                else
                begin
                    fin_next = 1'b1;
                    st_next = S_FMUL;
                end
            end
            S_ED:
            begin
                // d = pb - pa
                cmd = '{cmd: pti_pkg::CMD_DIV_STEP, sel: {i_reg[1:0], 2'd0}};
                st_next = S_EM;
            end
            S_EM:
            begin
                cmd = '{cmd: pti_pkg::CMD_EXACT, sel: 4'd0};
                st_next = S_EMW;
            end
            S_EMW:
                if (mul_done) st_next = S_EMC;
            S_EMC:
            begin
                cmd = '{cmd: pti_pkg::CMD_DIV_STEP, sel: 4'd3};
                st_next = S_EDV;
            end
            S_EDV:
            begin
                cmd = '{cmd: pti_pkg::CMD_DIV_START, sel: 4'd1};
                st_next = S_DIVW;
            end
            S_DIVW:
                if (!div_busy)
                begin
                    cmd = '{cmd: pti_pkg::CMD_DIV_DONE, sel: 4'd1};
                    if (i_reg + 4'd1 >= nterms) st_next = S_OUT;
                    else st_next = S_EPW;
                end
            S_EPW:
            begin
                cmd = '{cmd: pti_pkg::CMD_EXACT, sel: 4'd1};
                st_next = S_EPC;
            end
            S_EPC:
                if (mul_done)
                begin
                    cmd = '{cmd: pti_pkg::CMD_DIV_STEP, sel: 4'd1};
                    st_next = S_EPB;
                end
            S_EPB:
            begin
                cmd = '{cmd: pti_pkg::CMD_EXACT, sel: 4'd2};
                st_next = S_EDW;
            end
            S_EDW:
                if (mul_done)
                begin
                    cmd = '{cmd: pti_pkg::CMD_DIV_STEP, sel: 4'd2};
                    i_next = i_reg + 4'd1;
                    st_next = S_ED;
                end
            S_OUT:
                if (!out_stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; i_reg <= 4'd0; tgt_reg <= 2'd0; fin_reg <= 1'b0;
            k_reg <= 25'd0; op_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; i_reg <= i_next; tgt_reg <= tgt_next; fin_reg <= fin_next;
            k_reg <= k_next; op_reg <= op_next;
        end
    end
endmodule

// ===== sv/poly_trapezoid_integral_top.sv =====
// Top level of the polynomial trapezoid integrator.
// Usage:
//   Input channel in_valid/in_stall carries op, lower_bound, upper_bound, steps.
//   Output channel out_valid/out_stall returns integral (Q40.24) and overflow.
//   Configuration: cfg_we, cfg_index, cfg_data; index 0 term_count, 1..5 coef0..coef4.
// Sequence:
//   One beat is worked at a time. Trapezoid mode: a load, a divide for the step,
//   then steps+3 polynomial evaluations on the shared multiplier, then two final
//   products, after which the result beat is offered. Exact mode: per term one
//   product, a divide and two powers (none for the last term), then the result
//   is offered. The multiplier and divider are each shared by all these steps.
// Throughput: in_stall is high from acceptance until the result beat is taken.
// Reset: asynchronous, clears the controller to idle, term_count to 5, coefs to 0.
// Stall: the result holds on the ports while out_stall is high; no new input
//   beat is accepted until it is taken.
module poly_trapezoid_integral_top
#(
    parameter int MAX_TERMS = pti_pkg::MAX_TERMS_DEF,
    parameter int MAX_STEPS = pti_pkg::MAX_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic [20:0]        steps,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] integral,
    output logic               overflow
);
    pti_pkg::pti_cmd_t cmd;
    logic [3:0]  nterms;
    logic [24:0] nsteps;
    logic        mul_done, div_busy;

    pti_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .op(op),
                     .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
                     .nterms(nterms), .nsteps(nsteps), .mul_done(mul_done),
                     .div_busy(div_busy), .cmd(cmd));

    pti_datapath #(.MAX_TERMS(MAX_TERMS), .MAX_STEPS(MAX_STEPS)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .lower_bound(lower_bound),
        .upper_bound(upper_bound), .steps(steps), .cmd(cmd), .nterms(nterms),
        .nsteps(nsteps), .mul_done(mul_done), .div_busy(div_busy),
        .integral(integral), .overflow(overflow)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(integral))
        else $error("result changed under stall");
`endif
endmodule

// ===== verif/tb_poly_trapezoid_integral_top.sv =====
// Self-checking testbench for poly_trapezoid_integral_top: directed table plus random beats.
module tb_poly_trapezoid_integral_top;

    // Register map beyond term_count: coef0..coef4 follow, 6 and 7 are unmapped
    localparam logic [2:0] REG_COEF0  = 3'd1;
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    localparam longint S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN   = 64'sh8000_0000_0000_0000;
    localparam int     N_TERMS   = 5;
    localparam int     STEP_CAP  = 1048576;
    localparam int     IDLE_MAX  = 50000;   // cycles without any accepted beat
    localparam int     SETTLE    = 40;      // cycles after the last result
    localparam int     NUM_PHASE = 6;
    localparam int     PER_PHASE = 16;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [20:0]        steps;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] integral;
    logic               overflow;

    poly_trapezoid_integral_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .steps       (steps),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .integral    (integral),
        .overflow    (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register file, updated on every write we issue
    // ------------------------------------------------------------------
    logic [2:0] sh_terms;
    longint     sh_coef [N_TERMS];

    typedef struct {
        longint value;
        bit     sat;
    } area_t;

    area_t pending_areas[$];

    int  err_cnt;
    int  idle_cnt;
    bit  quiet;     // when set, neither side idles

    // ------------------------------------------------------------------
    // Fixed-point integrator model
    // ------------------------------------------------------------------
    function automatic longint unsigned abs_u(longint a);
        longint unsigned m;
        m = a;
        if (a < 0)
            m = 64'd0 - m;
        return m;
    endfunction

    function automatic longint signed_from(longint unsigned m, bit neg, inout bit sat);
        if (neg)
        begin
            if (m > 64'h8000_0000_0000_0000)
            begin
                sat = 1'b1;
                return S64_MIN;
            end
            return longint'(64'd0 - m);
        end
        if (m > 64'h7FFF_FFFF_FFFF_FFFF)
        begin
            sat = 1'b1;
            return S64_MAX;
        end
        return longint'(m);
    endfunction

    function automatic longint add_sat(longint a, longint b, inout bit sat);
        longint s;
        s = a + b;
        if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
        begin
            sat = 1'b1;
            return (a < 0) ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    function automatic longint sub_sat(longint a, longint b, inout bit sat);
        longint s;
        s = a - b;
        if ((a < 0) != (b < 0) && (s < 0) != (a < 0))
        begin
            sat = 1'b1;
            return (a < 0) ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // (a*b) >> sh with round half away from zero; |b| is capped at 2^32
    function automatic longint mul_shift(longint a, longint b, int sh, inout bit sat);
        longint unsigned ma, mb, hi_w, lo_w, top, bot, res;
        bit neg;
        ma   = abs_u(a);
        mb   = abs_u(b);
        neg  = (a < 0) != (b < 0);
        hi_w = ma >> 32;
        lo_w = ma & 64'hFFFF_FFFF;
        if (mb > 64'h1_0000_0000)
            mb = 64'h1_0000_0000;
        top = hi_w * mb;
        bot = lo_w * mb;
        if ((top >> (31 + sh)) != 64'd0)
        begin
            sat = 1'b1;
            return neg ? S64_MIN : S64_MAX;
        end
        res = (top << (32 - sh)) + ((bot + (64'd1 << (sh - 1))) >> sh);
        return signed_from(res, neg, sat);
    endfunction

    function automatic longint div_near(longint a, longint unsigned d, inout bit sat);
        longint unsigned m, q;
        m = abs_u(a);
        q = m / d;
        if (m % d >= d - d / 2)
            q = q + 1;
        return signed_from(q, a < 0, sat);
    endfunction

    function automatic int live_terms();
        int n;
        n = int'(sh_terms);
        if (n == 0)
            n = 1;
        if (n > N_TERMS)
            n = N_TERMS;
        return n;
    endfunction

    // Horner evaluation, saturating at every step
    function automatic longint horner(longint x, inout bit sat);
        int     n;
        longint acc;
        n   = live_terms();
        acc = sh_coef[n-1];
        for (int i = n - 2; i >= 0; i--)
            acc = add_sat(mul_shift(acc, x, 24, sat), sh_coef[i], sat);
        return acc;
    endfunction

    function automatic area_t integrate(logic mode, logic signed [31:0] lb,
                                        logic signed [31:0] ub, logic [20:0] nst);
        area_t  r;
        bit     sat;
        longint lo, hi, h, x, acc, ends, pa, pb, d, t;
        longint unsigned n;
        int     nt;
        sat = 1'b0;
        lo  = lb;
        hi  = ub;
        acc = 0;
        if (mode == pti_pkg::OP_TRAP)
        begin
            n = nst;
            if (n == 0)
                n = 1;
            if (n > STEP_CAP)
                n = STEP_CAP;
            h = div_near(hi - lo, n, sat);
            for (longint k = 0; k <= longint'(n); k++)
            begin
                x = lo + k * h;
                // sample point clamped to the Q8.24 operand range
                if (x > 64'sh7FFF_FFFF)
                begin
                    sat = 1'b1;
                    x = 64'sh7FFF_FFFF;
                end
                else if (x < -64'sh8000_0000)
                begin
                    sat = 1'b1;
                    x = -64'sh8000_0000;
                end
                acc = add_sat(acc, horner(x, sat), sat);
            end
            ends = add_sat(horner(lo, sat), horner(hi, sat), sat);
            r.value = sub_sat(mul_shift(acc, h, 24, sat), mul_shift(ends, h, 25, sat), sat);
        end
        else
        begin
            nt = live_terms();
            pa = lo;
            pb = hi;
            for (int i = 0; i < nt; i++)
            begin
                d   = sub_sat(pb, pa, sat);
                t   = div_near(mul_shift(d, sh_coef[i], 24, sat), i + 1, sat);
                acc = add_sat(acc, t, sat);
                if (i + 1 < nt)
                begin
                    pa = mul_shift(pa, lo, 24, sat);
                    pb = mul_shift(pb, hi, 24, sat);
                end
            end
            r.value = acc;
        end
        r.sat = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side stall pattern, one assignment per falling edge
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = idle_len();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_bad(string what, longint ev, bit eo);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch %s: expected integral %0d ovf %0b, got %0d ovf %0b",
                     what, ev, eo, integral, overflow);
    endtask

    always @(posedge clk)
    begin
        area_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_areas.size() == 0)
                report_bad("(no beat pending)", 0, 1'b0);
            else
            begin
                e = pending_areas.pop_front();
                if (integral !== e.value || overflow !== e.sat)
                    report_bad("(field)", e.value, e.sat);
            end
        end
    end

    // Watchdog: too long without any accepted beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= IDLE_MAX)
        begin
            $display("watchdog expired, %0d results pending", pending_areas.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Block idle: nothing outstanding, then let the pipeline settle
    task automatic drain();
        while (pending_areas.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == pti_pkg::REG_TERM_COUNT)
            sh_terms = val[2:0];
        else if (idx >= REG_COEF0 && idx < REG_COEF0 + N_TERMS)
            sh_coef[idx - REG_COEF0] = longint'($signed(val));
    endtask

    // typed: expected value given by the caller rather than the model
    task automatic send_beat(logic m, logic signed [31:0] lb, logic signed [31:0] ub,
                             logic [20:0] ns, bit typed, longint tv, bit tov);
        int    gap;
        area_t e;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= m;
        lower_bound <= lb;
        upper_bound <= ub;
        steps       <= ns;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
        begin
            e.value = tv;
            e.sat   = tov;
        end
        else
            e = integrate(m, lb, ub, ns);
        pending_areas.push_back(e);
        // the beat is taken: withdraw it before the block is idle again
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table: a row is either a register write or a beat
    // ------------------------------------------------------------------
    typedef struct {
        bit                 is_reg;
        logic [2:0]         idx;
        logic [31:0]        val;
        logic               m;
        logic signed [31:0] lb;
        logic signed [31:0] ub;
        logic [20:0]        ns;
        bit                 typed;
        longint             tv;
        bit                 tov;
    } row_t;

    row_t plan[$];

    function automatic void row_reg(logic [2:0] idx, logic [31:0] val);
        row_t r;
        r = '{default: 0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        plan.push_back(r);
    endfunction

    function automatic void row_beat(logic m, logic [31:0] lb, logic [31:0] ub,
                                     logic [20:0] ns, bit typed);
        row_t r;
        r = '{default: 0};
        r.m     = m;
        r.lb    = lb;
        r.ub    = ub;
        r.ns    = ns;
        r.typed = typed;
        plan.push_back(r);
    endfunction

    function automatic logic [31:0] rand_bound();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;  // within +-4.0
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 2))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef(int flavor);
        if (flavor == 0)
            return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;  // within +-2.0
        if (flavor == 1)
            return $urandom;
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    initial
    begin
        logic        m;
        logic [20:0] ns;
        int          flavor;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = pti_pkg::OP_TRAP;
        lower_bound = '0;
        upper_bound = '0;
        steps       = '0;
        err_cnt     = 0;
        idle_cnt    = 0;
        stall_left  = 0;
        quiet       = 1'b0;
        sh_terms    = 3'd5;
        foreach (sh_coef[i])
            sh_coef[i] = 0;

        // After reset every coefficient is zero, so the integral is plain zero
        row_beat(pti_pkg::OP_EXACT, 32'h8000_0000, 32'h7FFF_FFFF, 21'd0, 1'b1);
        row_beat(pti_pkg::OP_TRAP,  32'h8000_0000, 32'h7FFF_FFFF, 21'd1, 1'b1);
        row_beat(pti_pkg::OP_TRAP,  32'h0100_0000, 32'h0300_0000, 21'd0, 1'b1);
        // Quadratic 1 + 2x - 0.5x^2
        row_reg(pti_pkg::REG_TERM_COUNT, 32'd3);
        row_reg(REG_COEF0,          32'h0100_0000);
        row_reg(3'(REG_COEF0 + 1),  32'h0200_0000);
        row_reg(3'(REG_COEF0 + 2),  32'hFF80_0000);
        row_reg(REG_SPARE6,         32'hFFFF_FFFF);   // unmapped, must be ignored
        row_reg(REG_SPARE7,         32'h1234_5678);
        row_beat(pti_pkg::OP_TRAP,  32'h0000_0000, 32'h0200_0000, 21'd0, 1'b0);
        row_beat(pti_pkg::OP_TRAP,  32'h0000_0000, 32'h0200_0000, 21'd8, 1'b0);
        row_beat(pti_pkg::OP_TRAP,  32'h0200_0000, 32'hFF00_0000, 21'd5, 1'b0);  // upper below lower
        row_beat(pti_pkg::OP_EXACT, 32'h0200_0000, 32'hFF00_0000, 21'h1F_FFFF, 1'b0);
        row_beat(pti_pkg::OP_EXACT, 32'h0100_0000, 32'h0100_0000, 21'h10_0000, 1'b0);
        row_beat(pti_pkg::OP_TRAP,  32'h8000_0000, 32'h7FFF_FFFF, 21'd4, 1'b0);
        // Extreme coefficients, term count above the maximum: saturation
        row_reg(pti_pkg::REG_TERM_COUNT, 32'd7);
        row_reg(REG_COEF0,          32'h7FFF_FFFF);
        row_reg(3'(REG_COEF0 + 1),  32'h8000_0000);
        row_reg(3'(REG_COEF0 + 2),  32'h7FFF_FFFF);
        row_reg(3'(REG_COEF0 + 3),  32'h8000_0000);
        row_reg(3'(REG_COEF0 + 4),  32'h7FFF_FFFF);
        row_beat(pti_pkg::OP_EXACT, 32'h8000_0000, 32'h7FFF_FFFF, 21'd0, 1'b0);
        row_beat(pti_pkg::OP_TRAP,  32'h8000_0000, 32'h7FFF_FFFF, 21'd3, 1'b0);
        row_beat(pti_pkg::OP_TRAP,  32'hFF00_0000, 32'h0100_0000, 21'd2, 1'b0);
        // Term count zero behaves as a single term
        row_reg(pti_pkg::REG_TERM_COUNT, 32'd0);
        row_beat(pti_pkg::OP_EXACT, 32'hFE00_0000, 32'h0300_0000, 21'd7, 1'b0);
        row_beat(pti_pkg::OP_TRAP,  32'hFE00_0000, 32'h0300_0000, 21'd7, 1'b0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                drain();
                reg_write(plan[i].idx, plan[i].val);
            end
            else
                send_beat(plan[i].m, plan[i].lb, plan[i].ub, plan[i].ns,
                          plan[i].typed, plan[i].tv, plan[i].tov);
        end

        // Random phases: fresh register settings each time, first and last use extremes for all but coef0
        for (int ph = 0; ph < NUM_PHASE; ph++)
        begin
            drain();
            quiet  = (ph == 2);
            flavor = (ph == 0 || ph == NUM_PHASE - 1) ? 2 : $urandom_range(0, 1);
            reg_write(pti_pkg::REG_TERM_COUNT, (ph == 0) ? 32'd1 :
                      (ph == NUM_PHASE - 1) ? 32'd5 : $urandom_range(0, 7));
            for (int c = 0; c < N_TERMS; c++)
                reg_write(3'(REG_COEF0 + c), rand_coef((c == 0 && flavor == 2) ? 0 : flavor));
            if ($urandom_range(0, 1))
                reg_write($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, $urandom);
            for (int it = 0; it < PER_PHASE; it++)
            begin
                m = 1'($urandom_range(0, 1));
                // long step counts only in exact mode, where they cost nothing
                if (m == pti_pkg::OP_EXACT)
                    ns = 21'($urandom);
                else if ($urandom_range(0, 9) != 0)
                    ns = 21'($urandom_range(0, 16));
                else
                    ns = 21'($urandom_range(17, 64));
                send_beat(m, rand_bound(), rand_bound(), ns, 1'b0, 0, 1'b0);
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        drain();

        if (err_cnt == 0 && pending_areas.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
